### hw/rtl/id_pool_allocator_with_event_fifo_defines.svh
// Assertion macros used by the checker file of the id pool block.
// Depends on nothing; included by bare file name.
`ifndef ID_POOL_ALLOCATOR_WITH_EVENT_FIFO_DEFINES_SVH
`define ID_POOL_ALLOCATOR_WITH_EVENT_FIFO_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define IDP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("id pool check failed");

// Next-cycle implication, disabled while reset is high.
`define IDP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("id pool check failed");

`endif

### hw/rtl/idpool_pkg.sv
// Package for the id pool allocator: widths, codes, controller types.
// Depends on nothing; used by every module of the block.
package idpool_pkg;

  localparam int ELEMENTS_DEF    = 64;
  localparam int EVENT_DEPTH_DEF = 4096;

  localparam int CMD_W    = 2;
  localparam int PARENT_W = 16;
  localparam int ELEM_W   = 7;
  localparam int STATUS_W = 2;
  localparam int GIVEN_W  = 6;
  localparam int FREE_W   = 7;
  localparam int PEND_W   = 13;

  localparam logic KIND_ACQUIRED = 1'b0;
  localparam logic KIND_RELEASED = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_POP     = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_ID   = 2'd2,
    ST_NO_EVENT = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the command and issue the memory reads
    logic exec;  // apply the command and register the result
  } ctrl_t;

endpackage

### hw/rtl/id_pool_allocator_with_event_fifo.sv
// Top level of the id pool allocator with its event FIFO.
// Depends on idpool_pkg, idpool_ctrl and idpool_dp.
//
// A command (cmd, parent_id, release_id) is transferred at a rising edge
// where start is high and busy is low. Acquire pops an id from the free
// stack, release returns one, pop reads the oldest logged event, and clear
// empties the event FIFO. Every command yields exactly one result.
// The result is on the output ports for the single cycle in which done is
// high, and it is transferred at the edge that ends that cycle; the
// receiver cannot stall, so nothing waits on it.
// The registered reads of the free stack, the element table and the
// event memory are taken at the transfer edge; the EXEC state then
// applies the command and registers the result, which done marks.
// busy is low again while done is high, so a new command can be taken in
// that same cycle; while a command executes busy stays high, so commands
// are taken one at a time.
// Reset restores the free stack to ascending order, marks every id free and
// empties the FIFO at once; no clearing pass runs, so a command can be
// taken in the first cycle after reset.
module id_pool_allocator_with_event_fifo #(
  parameter int ELEMENTS    = idpool_pkg::ELEMENTS_DEF,
  parameter int EVENT_DEPTH = idpool_pkg::EVENT_DEPTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  output logic                                      busy,
  input  logic        [idpool_pkg::CMD_W-1:0]       cmd,
  input  logic signed [idpool_pkg::PARENT_W-1:0]    parent_id,
  input  logic signed [$clog2(ELEMENTS):0]          release_id,
  output logic                                      done,
  output logic        [idpool_pkg::STATUS_W-1:0]    status,
  output logic        [$clog2(ELEMENTS)-1:0]        given_id,
  output logic                                      event_lost,
  output logic                                      ev_valid,
  output logic                                      ev_kind,
  output logic        [$clog2(ELEMENTS)-1:0]        ev_element,
  output logic signed [idpool_pkg::PARENT_W-1:0]    ev_parent,
  output logic        [$clog2(ELEMENTS+1)-1:0]      free_count,
  output logic        [$clog2(EVENT_DEPTH+1)-1:0]   pending_events
);
  import idpool_pkg::*;

  // Load and execute commands from the controller to the datapath.
  ctrl_t ctrl;

  idpool_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .ctrl  (ctrl),
    .busy  (busy),
    .done  (done)
  );

  // The datapath holds all pool and FIFO state; free_count and
  // pending_events show the state left by the last command.
  idpool_dp #(
    .ELEMENTS    (ELEMENTS),
    .EVENT_DEPTH (EVENT_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .cmd            (cmd),
    .parent_id      (parent_id),
    .release_id     (release_id),
    .status         (status),
    .given_id       (given_id),
    .event_lost     (event_lost),
    .ev_valid       (ev_valid),
    .ev_kind        (ev_kind),
    .ev_element     (ev_element),
    .ev_parent      (ev_parent),
    .free_count     (free_count),
    .pending_events (pending_events)
  );

endmodule

### hw/rtl/idpool_ctrl.sv
// Controller state machine of the id pool allocator.
// Depends on idpool_pkg.
module idpool_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output idpool_pkg::ctrl_t  ctrl,
  output logic               busy,
  output logic               done
);
  import idpool_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ctrl.exec;
    end
  end

  always_comb begin
    state_next = state;
    ctrl.load  = 1'b0;
    ctrl.exec  = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl.exec  = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

### hw/rtl/idpool_dp.sv
// Datapath of the id pool allocator: free stack, element table, event FIFO.
// Depends on idpool_pkg; driven by idpool_ctrl.
module idpool_dp #(
  parameter int ELEMENTS    = idpool_pkg::ELEMENTS_DEF,
  parameter int EVENT_DEPTH = idpool_pkg::EVENT_DEPTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  idpool_pkg::ctrl_t                         ctrl,
  input  logic        [idpool_pkg::CMD_W-1:0]       cmd,
  input  logic signed [idpool_pkg::PARENT_W-1:0]    parent_id,
  input  logic signed [$clog2(ELEMENTS):0]          release_id,
  output logic        [idpool_pkg::STATUS_W-1:0]    status,
  output logic        [$clog2(ELEMENTS)-1:0]        given_id,
  output logic                                      event_lost,
  output logic                                      ev_valid,
  output logic                                      ev_kind,
  output logic        [$clog2(ELEMENTS)-1:0]        ev_element,
  output logic signed [idpool_pkg::PARENT_W-1:0]    ev_parent,
  output logic        [$clog2(ELEMENTS+1)-1:0]      free_count,
  output logic        [$clog2(EVENT_DEPTH+1)-1:0]   pending_events
);
  import idpool_pkg::*;

  localparam int IW  = $clog2(ELEMENTS);
  localparam int TW  = $clog2(ELEMENTS + 1);
  localparam int EW  = $clog2(EVENT_DEPTH);
  localparam int CW  = $clog2(EVENT_DEPTH + 1);
  localparam int EVW = 1 + IW + PARENT_W;
  localparam int TBW = 1 + PARENT_W;

  // Control state.
  logic [TW-1:0] free_top, free_top_next;
  logic [TW-1:0] min_top, min_top_next;
  logic [EW-1:0] ev_head, ev_head_next;
  logic [EW-1:0] ev_tail, ev_tail_next;
  logic [CW-1:0] ev_count, ev_count_next;

  // Captured command.
  cmd_t                 cmd_q;
  logic [PARENT_W-1:0]  parent_q;
  logic [IW:0]          elem_q;

  // Memories and their registered read data.
  logic [IW-1:0]  stack_mem [ELEMENTS];
  logic [TBW-1:0] tbl_mem   [ELEMENTS];
  logic [EVW-1:0] ev_mem    [EVENT_DEPTH];
  logic [IW-1:0]  stack_rd;
  logic [TBW-1:0] tbl_rd;
  logic [EVW-1:0] ev_rd;

  logic           stack_we, tbl_we, ev_we;
  logic [IW-1:0]  stack_wa, tbl_wa;
  logic [IW-1:0]  stack_wd;
  logic [TBW-1:0] tbl_wd;
  logic [EVW-1:0] ev_wd;

  // Result next values.
  logic [STATUS_W-1:0] status_next;
  logic [IW-1:0]       given_next;
  logic                lost_next;
  logic                evv_next;
  logic                evk_next;
  logic [IW-1:0]       eve_next;
  logic [PARENT_W-1:0] evp_next;

  // Decode helpers.
  logic [TW-1:0]       slot;
  logic                slot_orig;
  logic [IW-1:0]       acq_id;
  logic [IW-1:0]       rel_mag;
  logic                rel_nop;
  logic                rel_ok;
  logic [IW-1:0]       rel_id;
  logic                fifo_full;
  logic [EW-1:0]       tail_inc, head_inc;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q    <= cmd_t'(cmd);
      parent_q <= parent_id;
      elem_q   <= release_id;
    end
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_wa] <= stack_wd;
    end
    if (ctrl.load) begin
      stack_rd <= stack_mem[IW'(TW'(free_top - 1'b1))];
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    if (ctrl.load) begin
      tbl_rd <= tbl_mem[release_id[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ev_we) begin
      ev_mem[ev_tail] <= ev_wd;
    end
    if (ctrl.load) begin
      ev_rd <= ev_mem[ev_head];
    end
  end

  always_comb begin
    // Slots below the lowest stack top ever reached still hold reset order.
    slot      = TW'(free_top - 1'b1);
    slot_orig = (slot < min_top);
    acq_id    = slot_orig ? IW'(ELEMENTS - 1 - int'(slot)) : stack_rd;

    // Ids at or above ELEMENTS - min_top were never handed out, so their
    // table entries were never written and are treated as inactive.
    rel_mag   = elem_q[IW-1:0];
    rel_nop   = (elem_q == '1);
    rel_id    = rel_mag;
    rel_ok    = !elem_q[IW] && (int'(rel_mag) < ELEMENTS) &&
                ((int'(rel_mag) + int'(min_top)) < ELEMENTS) &&
                tbl_rd[TBW-1] && (int'(free_top) < ELEMENTS);

    fifo_full = (int'(ev_count) >= EVENT_DEPTH);
    tail_inc  = (ev_tail == EW'(EVENT_DEPTH - 1)) ? '0 : EW'(ev_tail + 1'b1);
    head_inc  = (ev_head == EW'(EVENT_DEPTH - 1)) ? '0 : EW'(ev_head + 1'b1);

    free_top_next = free_top;
    min_top_next  = min_top;
    ev_head_next  = ev_head;
    ev_tail_next  = ev_tail;
    ev_count_next = ev_count;
    stack_we = 1'b0;
    stack_wa = IW'(free_top);
    stack_wd = rel_id;
    tbl_we   = 1'b0;
    tbl_wa   = acq_id;
    tbl_wd   = {1'b1, parent_q};
    ev_we    = 1'b0;
    ev_wd    = {KIND_ACQUIRED, acq_id, parent_q};
    status_next = ST_OK;
    given_next  = '0;
    lost_next   = 1'b0;
    evv_next    = 1'b0;
    evk_next    = 1'b0;
    eve_next    = '0;
    evp_next    = '0;

    if (ctrl.exec) begin
      case (cmd_q)
        CMD_ACQUIRE: begin
          if (free_top == '0) begin
            status_next = ST_EMPTY;
          end else begin
            free_top_next = slot;
            if (slot_orig) begin
              min_top_next = slot;
            end
            tbl_we     = 1'b1;
            given_next = acq_id;
            if (fifo_full) begin
              lost_next = 1'b1;
            end else begin
              ev_we         = 1'b1;
              ev_tail_next  = tail_inc;
              ev_count_next = CW'(ev_count + 1'b1);
            end
          end
        end
        CMD_RELEASE: begin
          if (rel_nop) begin
            status_next = ST_OK;
          end else if (!rel_ok) begin
            status_next = ST_BAD_ID;
          end else begin
            tbl_we        = 1'b1;
            tbl_wa        = rel_id;
            tbl_wd        = {1'b0, {PARENT_W{1'b1}}};
            stack_we      = 1'b1;
            free_top_next = TW'(free_top + 1'b1);
            ev_wd         = {KIND_RELEASED, rel_id, tbl_rd[PARENT_W-1:0]};
            if (fifo_full) begin
              lost_next = 1'b1;
            end else begin
              ev_we         = 1'b1;
              ev_tail_next  = tail_inc;
              ev_count_next = CW'(ev_count + 1'b1);
            end
          end
        end
        CMD_POP: begin
          if (ev_count == '0) begin
            status_next = ST_NO_EVENT;
          end else begin
            evv_next      = 1'b1;
            evk_next      = ev_rd[EVW-1];
            eve_next      = ev_rd[PARENT_W +: IW];
            evp_next      = ev_rd[PARENT_W-1:0];
            ev_head_next  = head_inc;
            ev_count_next = CW'(ev_count - 1'b1);
          end
        end
        CMD_CLEAR: begin
          ev_head_next  = '0;
          ev_tail_next  = '0;
          ev_count_next = '0;
        end
        default: status_next = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_top <= TW'(ELEMENTS);
      min_top  <= TW'(ELEMENTS);
      ev_head  <= '0;
      ev_tail  <= '0;
      ev_count <= '0;
    end else begin
      free_top <= free_top_next;
      min_top  <= min_top_next;
      ev_head  <= ev_head_next;
      ev_tail  <= ev_tail_next;
      ev_count <= ev_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      status     <= status_next;
      given_id   <= given_next;
      event_lost <= lost_next;
      ev_valid   <= evv_next;
      ev_kind    <= evk_next;
      ev_element <= eve_next;
      ev_parent  <= evp_next;
    end
  end

  assign free_count     = free_top;
  assign pending_events = ev_count;

endmodule

### hw/rtl/idpool_checker.sv
// Port-level checks for the id pool allocator, bound to its top level.
// Depends on idpool_pkg and the assertion macros header.
`include "id_pool_allocator_with_event_fifo_defines.svh"

module idpool_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                done,
  input logic [idpool_pkg::STATUS_W-1:0]     status,
  input logic                                ev_valid,
  input logic                                event_lost
);
  import idpool_pkg::*;

  // A transferred command makes the block busy in the next cycle.
  `IDP_ASSERT_NXT(a_busy_after_start, clk, rst, start && !busy, busy)
  // Its result is signalled by done after the command has passed through EXEC.
  `IDP_ASSERT_IMP(a_done_latency, clk, rst, start && !busy, ##2 done)
  // The result cycle is also a cycle in which a new command can be taken.
  `IDP_ASSERT_IMP(a_done_not_busy, clk, rst, done, !busy)
  // A popped event always comes with an ok status.
  `IDP_ASSERT_IMP(a_pop_status, clk, rst, done && ev_valid, status == ST_OK)
  // A dropped event only happens on a command that otherwise succeeded.
  `IDP_ASSERT_IMP(a_lost_status, clk, rst, done && event_lost,
                  status == ST_OK && !ev_valid)

endmodule

bind id_pool_allocator_with_event_fifo idpool_checker u_idpool_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .status     (status),
  .ev_valid   (ev_valid),
  .event_lost (event_lost)
);
